/* hw/rtl/ppw_pkg.sv */
package ppw_pkg;

  // Packed lane layout of the lattice and reciprocal registers
  localparam int LANE_BITS  = 21;
  localparam int RECIP_FRAC = 18;

  // Configuration port
  localparam int CFG_DATA_W = 3 * LANE_BITS;
  localparam int CFG_IDX_W  = 3;

  // Reduced fractional coordinate: signed Q.18, clamped to +-2^41
  localparam int     FRAC_W     = 43;
  localparam longint FRAC_LIMIT = longint'(1) << 41;

  localparam int STATUS_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LATTICE_A,
    REG_LATTICE_B,
    REG_LATTICE_C,
    REG_RECIP_A,
    REG_RECIP_B,
    REG_RECIP_C,
    REG_PERIODIC_MASK,
    REG_LATTICE_PRESENT
  } cfg_reg_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK         = 2'd0,
    STATUS_NO_LATTICE = 2'd1,
    STATUS_SATURATED  = 2'd2
  } status_e;

  typedef logic signed [LANE_BITS-1:0] lane_t;

  // Lane n of a packed register: x in the low bits, z in the high bits
  function automatic lane_t get_lane(input logic [CFG_DATA_W-1:0] vec, input int unsigned n);
    return vec[n*LANE_BITS +: LANE_BITS];
  endfunction

endpackage

/* hw/rtl/ppw_if.sv */
// Position channel
interface ppw_pos_if #(
  parameter int COORD_WIDTH = 21
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] pos_x;
  logic signed [COORD_WIDTH-1:0] pos_y;
  logic signed [COORD_WIDTH-1:0] pos_z;

  modport source (output valid, pos_x, pos_y, pos_z, input ready);
  modport sink   (input valid, pos_x, pos_y, pos_z, output ready);
endinterface

// Result channel
interface ppw_res_if #(
  parameter int COORD_WIDTH = 21
);
  logic                             valid;
  logic                             ready;
  logic signed [COORD_WIDTH-1:0]    wrapped_x;
  logic signed [COORD_WIDTH-1:0]    wrapped_y;
  logic signed [COORD_WIDTH-1:0]    wrapped_z;
  logic [ppw_pkg::STATUS_W-1:0]     status;

  modport source (output valid, wrapped_x, wrapped_y, wrapped_z, status, input ready);
  modport sink   (input valid, wrapped_x, wrapped_y, wrapped_z, status, output ready);
endinterface

// Configuration write channel
interface ppw_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [ppw_pkg::CFG_IDX_W-1:0]  index;
  logic [ppw_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* hw/rtl/ppw_prod3.sv */
// Three independent signed products, registered
module ppw_prod3 #(
  parameter int A_WIDTH = 21,
  parameter int B_WIDTH = 21
) (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  logic signed [A_WIDTH-1:0]         a_i    [3],
  input  logic signed [B_WIDTH-1:0]         b_i    [3],
  output logic signed [A_WIDTH+B_WIDTH-1:0] prod_o [3]
);

  logic signed [A_WIDTH+B_WIDTH-1:0] prod_q [3];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int n = 0; n < 3; n++) begin
        prod_q[n] <= a_i[n] * b_i[n];
      end
    end
  end

  assign prod_o = prod_q;

endmodule

/* hw/rtl/periodic_position_wrap_unit.sv */
// Periodic position wrap unit.
// Wraps Cartesian positions (signed, FRAC_BITS fraction bits) into a periodic
// cell. pos_i takes one position per transfer, res_o returns one wrapped
// position plus status per input, in order. cfg_i writes the lattice vectors,
// the reciprocal rows, the periodic mask and the lattice-present flag; it is
// always ready and must only be used while the unit holds no item.
// A result reaches res_o through the input register, reciprocal products,
// fractional reduce, lattice products and output register. Throughput: one
// position per cycle while res_o takes results, set by the five-stage
// pipeline where every stage holds one item.
// Each stage has its own valid bit and takes a new item whenever it is empty or
// its successor moves, so bubbles are squeezed out when res_o stalls; pos_i
// drops ready only once all five stages are full. Nothing is lost or repeated.
// Reset clears all valid bits and every configuration register to zero
// (mask zero: positions pass through with status ok).
module periodic_position_wrap_unit #(
  parameter int COORD_WIDTH = 21,
  parameter int FRAC_BITS   = 10
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ppw_cfg_if.sink     cfg_i,
  ppw_pos_if.sink     pos_i,
  ppw_res_if.source   res_o
);

  localparam int LANE_W  = ppw_pkg::LANE_BITS;
  localparam int RFRAC   = ppw_pkg::RECIP_FRAC;
  localparam int FRAC_W  = ppw_pkg::FRAC_W;
  localparam int PROD1_W = COORD_WIDTH + LANE_W;
  localparam int SUM1_W  = PROD1_W + 2;
  localparam int WRAP_W  = FRAC_BITS + RFRAC;
  localparam int SHR_W   = SUM1_W - FRAC_BITS;
  localparam int SHX_W   = (SHR_W > FRAC_W) ? SHR_W : FRAC_W;
  localparam int PROD2_W = LANE_W + FRAC_W;
  localparam int SUM2_W  = PROD2_W + 2;
  localparam int RND_W   = SUM2_W - RFRAC;

  localparam logic signed [SHX_W-1:0]  FRAC_HI  = SHX_W'(ppw_pkg::FRAC_LIMIT);
  localparam logic signed [SHX_W-1:0]  FRAC_LO  = SHX_W'(-ppw_pkg::FRAC_LIMIT);
  localparam logic signed [FRAC_W-1:0] FRAC_ONE = FRAC_W'(longint'(1) << RFRAC);
  localparam logic signed [SUM2_W-1:0] RND_HALF = SUM2_W'(longint'(1) << (RFRAC - 1));
  localparam logic signed [RND_W-1:0]  OUT_HI   =
    RND_W'((longint'(1) << (COORD_WIDTH - 1)) - 1);
  localparam logic signed [RND_W-1:0]  OUT_LO   = RND_W'(-(longint'(1) << (COORD_WIDTH - 1)));

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [ppw_pkg::CFG_DATA_W-1:0] lat_q [3];
  logic [ppw_pkg::CFG_DATA_W-1:0] rcp_q [3];
  logic [2:0]                     mask_q;
  logic                           present_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lat_q     <= '{default: '0};
      rcp_q     <= '{default: '0};
      mask_q    <= '0;
      present_q <= 1'b0;
    end else if (cfg_i.valid) begin
      case (ppw_pkg::cfg_reg_e'(cfg_i.index))
        ppw_pkg::REG_LATTICE_A:       lat_q[0]  <= cfg_i.data;
        ppw_pkg::REG_LATTICE_B:       lat_q[1]  <= cfg_i.data;
        ppw_pkg::REG_LATTICE_C:       lat_q[2]  <= cfg_i.data;
        ppw_pkg::REG_RECIP_A:         rcp_q[0]  <= cfg_i.data;
        ppw_pkg::REG_RECIP_B:         rcp_q[1]  <= cfg_i.data;
        ppw_pkg::REG_RECIP_C:         rcp_q[2]  <= cfg_i.data;
        ppw_pkg::REG_PERIODIC_MASK:   mask_q    <= cfg_i.data[2:0];
        ppw_pkg::REG_LATTICE_PRESENT: present_q <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

  // Lane views: reciprocal row k lane n, lattice vector k component i
  logic signed [LANE_W-1:0] rcp_lane [3][3];
  logic signed [LANE_W-1:0] lat_col  [3][3];

  for (genvar k = 0; k < 3; k++) begin : g_lanes
    for (genvar n = 0; n < 3; n++) begin : g_lane
      assign rcp_lane[k][n] = ppw_pkg::get_lane(rcp_q[k], n);
      assign lat_col[n][k]  = ppw_pkg::get_lane(lat_q[k], n);
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline flow control: a stage loads when empty or when its item moves on
  // ---------------------------------------------------------------------------
  logic v1_q, v2_q, v3_q, v4_q, v5_q;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;

  assign rdy5 = !v5_q || res_o.ready;
  assign rdy4 = !v4_q || rdy5;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;

  assign pos_i.ready = rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= pos_i.valid;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
      if (rdy5) v5_q <= v4_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: input register
  // ---------------------------------------------------------------------------
  logic signed [COORD_WIDTH-1:0] p1_q [3];

  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      p1_q[0] <= pos_i.pos_x;
      p1_q[1] <= pos_i.pos_y;
      p1_q[2] <= pos_i.pos_z;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: position times reciprocal rows, plus bypass decision
  // ---------------------------------------------------------------------------
  logic signed [PROD1_W-1:0]     prod1 [3][3];
  logic signed [COORD_WIDTH-1:0] p2_q  [3];
  logic                          byp2_q;
  ppw_pkg::status_e              bstat2_q;
  logic [2:0]                    mask2_q;

  for (genvar k = 0; k < 3; k++) begin : g_frac_mul
    ppw_prod3 #(
      .A_WIDTH (COORD_WIDTH),
      .B_WIDTH (LANE_W)
    ) u_prod (
      .clk_i  (clk_i),
      .en_i   (rdy2),
      .a_i    (p1_q),
      .b_i    (rcp_lane[k]),
      .prod_o (prod1[k])
    );
  end

  always_ff @(posedge clk_i) begin
    if (rdy2) begin
      p2_q     <= p1_q;
      byp2_q   <= (mask_q == 3'b000) || !present_q;
      bstat2_q <= (mask_q == 3'b000) ? ppw_pkg::STATUS_OK : ppw_pkg::STATUS_NO_LATTICE;
      mask2_q  <= mask_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: dot product sum, wrap, reduce to Q.18, clamp
  // ---------------------------------------------------------------------------
  logic signed [SUM1_W-1:0] sum1 [3];
  logic signed [SUM1_W-1:0] sel1 [3];
  logic signed [SHR_W-1:0]  shr1 [3];
  logic signed [SHX_W-1:0]  shx1 [3];
  logic signed [FRAC_W-1:0] f3_d [3];
  logic                     sat3_d;

  always_comb begin
    sat3_d = 1'b0;
    for (int k = 0; k < 3; k++) begin
      sum1[k] = SUM1_W'(prod1[k][0]) + SUM1_W'(prod1[k][1]) + SUM1_W'(prod1[k][2]);
      // wrapping keeps only the fraction bits, i.e. subtracts the floor
      sel1[k] = mask2_q[k] ? SUM1_W'(sum1[k][WRAP_W-1:0]) : sum1[k];
      shr1[k] = sel1[k][SUM1_W-1:FRAC_BITS];
      shx1[k] = SHX_W'(shr1[k]);
      if (shx1[k] > FRAC_HI) begin
        f3_d[k] = FRAC_W'(FRAC_HI);
        sat3_d  = 1'b1;
      end else if (shx1[k] < FRAC_LO) begin
        f3_d[k] = FRAC_W'(FRAC_LO);
        sat3_d  = 1'b1;
      end else begin
        f3_d[k] = FRAC_W'(shx1[k]);
      end
    end
  end

  logic signed [FRAC_W-1:0]      f3_q [3];
  logic                          sat3_q;
  logic signed [COORD_WIDTH-1:0] p3_q [3];
  logic                          byp3_q;
  ppw_pkg::status_e              bstat3_q;
  logic [2:0]                    mask3_q;

  always_ff @(posedge clk_i) begin
    if (rdy3) begin
      f3_q     <= f3_d;
      sat3_q   <= sat3_d;
      p3_q     <= p2_q;
      byp3_q   <= byp2_q;
      bstat3_q <= bstat2_q;
      mask3_q  <= mask2_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: lattice vectors times fractional coordinates
  // ---------------------------------------------------------------------------
  logic signed [PROD2_W-1:0]     prod2 [3][3];
  logic signed [COORD_WIDTH-1:0] p4_q  [3];
  logic                          byp4_q;
  ppw_pkg::status_e              bstat4_q;
  logic                          sat4_q;

  for (genvar i = 0; i < 3; i++) begin : g_cart_mul
    ppw_prod3 #(
      .A_WIDTH (LANE_W),
      .B_WIDTH (FRAC_W)
    ) u_prod (
      .clk_i  (clk_i),
      .en_i   (rdy4),
      .a_i    (lat_col[i]),
      .b_i    (f3_q),
      .prod_o (prod2[i])
    );
  end

  always_ff @(posedge clk_i) begin
    if (rdy4) begin
      p4_q     <= p3_q;
      byp4_q   <= byp3_q;
      bstat4_q <= bstat3_q;
      sat4_q   <= sat3_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 5: sum, round half up, saturate, select bypass
  // ---------------------------------------------------------------------------
  logic signed [SUM2_W-1:0]      sum2 [3];
  logic signed [SUM2_W-1:0]      rnd2 [3];
  logic signed [RND_W-1:0]       rsh2 [3];
  logic signed [COORD_WIDTH-1:0] w5_d [3];
  logic                          sat5;
  ppw_pkg::status_e              stat5_d;

  always_comb begin
    sat5 = 1'b0;
    for (int i = 0; i < 3; i++) begin
      sum2[i] = SUM2_W'(prod2[i][0]) + SUM2_W'(prod2[i][1]) + SUM2_W'(prod2[i][2]);
      rnd2[i] = sum2[i] + RND_HALF;
      rsh2[i] = rnd2[i][SUM2_W-1:RFRAC];
      if (rsh2[i] > OUT_HI) begin
        w5_d[i] = COORD_WIDTH'(OUT_HI);
        sat5    = 1'b1;
      end else if (rsh2[i] < OUT_LO) begin
        w5_d[i] = COORD_WIDTH'(OUT_LO);
        sat5    = 1'b1;
      end else begin
        w5_d[i] = COORD_WIDTH'(rsh2[i]);
      end
    end
    if (byp4_q) begin
      w5_d    = p4_q;
      stat5_d = bstat4_q;
    end else if (sat4_q || sat5) begin
      stat5_d = ppw_pkg::STATUS_SATURATED;
    end else begin
      stat5_d = ppw_pkg::STATUS_OK;
    end
  end

  logic signed [COORD_WIDTH-1:0] w5_q [3];
  ppw_pkg::status_e              stat5_q;

  always_ff @(posedge clk_i) begin
    if (rdy5) begin
      w5_q    <= w5_d;
      stat5_q <= stat5_d;
    end
  end

  assign res_o.valid     = v5_q;
  assign res_o.wrapped_x = w5_q[0];
  assign res_o.wrapped_y = w5_q[1];
  assign res_o.wrapped_z = w5_q[2];
  assign res_o.status    = stat5_q;

`ifndef NO_ASSERTIONS
  // Input back-pressure only when every stage holds an item
  a_full_when_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pos_i.ready |-> (v1_q && v2_q && v3_q && v4_q && v5_q))
    else $error("input stalled while pipeline has a bubble");

  // Wrapped fractional coordinates lie in [0, 1)
  a_wrap_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v3_q && !byp3_q) |->
      ((!mask3_q[0] || (f3_q[0] >= 0 && f3_q[0] < FRAC_ONE)) &&
       (!mask3_q[1] || (f3_q[1] >= 0 && f3_q[1] < FRAC_ONE)) &&
       (!mask3_q[2] || (f3_q[2] >= 0 && f3_q[2] < FRAC_ONE))))
    else $error("wrapped fractional coordinate out of range");

  // A fractional clamp must surface as saturated status
  a_frac_sat_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v4_q && rdy5 && !byp4_q && sat4_q) |=> (stat5_q == ppw_pkg::STATUS_SATURATED))
    else $error("fractional clamp lost on the way to status");

  // Bypassed items leave unchanged
  a_bypass_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v4_q && rdy5 && byp4_q) |=>
      (w5_q[0] == $past(p4_q[0]) && w5_q[1] == $past(p4_q[1]) &&
       w5_q[2] == $past(p4_q[2]) && stat5_q == $past(bstat4_q)))
    else $error("bypassed position altered");
`endif

endmodule
